// File: hdl/fbfla_pkg.sv
`timescale 1ns / 1ps

package fbfla_pkg;

    // Default sizes
    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_ADDR_WIDTH  = 32;

    // Fixed field widths
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int BLOCK_W     = 16;
    localparam int GROW_W      = 9;
    localparam int BASE_W      = 32;
    localparam int LIMIT_W     = 9;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_COUNT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT  = 8'd3;

    // Register reset values
    localparam logic [BLOCK_W-1:0] RST_BLOCK_BYTES = 16'd64;
    localparam logic [GROW_W-1:0]  RST_GROW_COUNT  = 9'd4;
    localparam logic [BASE_W-1:0]  RST_POOL_BASE   = 32'd0;
    localparam logic [LIMIT_W-1:0] RST_POOL_LIMIT  = 9'd256;

endpackage

// File: hdl/fbfla_stack_ram.sv
`timescale 1ns / 1ps

module fbfla_stack_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/fixed_block_free_list_allocator_unit.sv
`timescale 1ns / 1ps

// Fixed-size block allocator over a stack of free addresses held in a single-port-write
// RAM with a registered read. A free (tuser = 1) pushes tdata (status overflow if no carved
// block is out) and registers its answer at the edge of its transfer; an allocate pops the
// top entry and answers in the next cycle, since the stack read is registered. An allocate
// on an empty stack answers exhausted if the chunk would pass the pool limit, else carves
// grow_count blocks (zero counts as one): the carved*block_bytes product is registered in
// the transfer cycle, ST_BASE does the base add, then ST_FILL makes one RAM write per block
// through a single shared address adder and returns the highest address of the chunk. The
// input is not ready while an item is in progress or while an earlier result cannot leave
// the output register. Only entries below the fill count are read, so no reset clearing.
module fixed_block_free_list_allocator_unit #(
    parameter int STACK_DEPTH = fbfla_pkg::DEF_STACK_DEPTH,
    parameter int ADDR_WIDTH  = fbfla_pkg::DEF_ADDR_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fbfla_pkg::DATA_W-1:0]        s_tdata,   // [31:0] block_address
    input  logic [0:0]                          s_tuser,   // [0] opcode
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fbfla_pkg::DATA_W-1:0]        m_tdata,   // [31:0] given_address
    output logic [fbfla_pkg::STATUS_W-1:0]      m_tuser,   // [1:0] status
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import fbfla_pkg::*;

    localparam int IDX_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int LW     = ((CNT_W > GROW_W) ? CNT_W : GROW_W) + 1;
    localparam int PROD_W = CNT_W + BLOCK_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_BASE,
        ST_FILL
    } state_t;

    state_t state_reg;

    // configuration
    logic [BLOCK_W-1:0] block_bytes_reg;
    logic [GROW_W-1:0]  grow_count_reg;
    logic [BASE_W-1:0]  pool_base_reg;
    logic [LIMIT_W-1:0] pool_limit_reg;

    // allocator state
    logic [CNT_W-1:0] free_count_reg;
    logic [CNT_W-1:0] carved_reg;

    // refill working registers
    logic [ADDR_WIDTH-1:0] prod_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [GROW_W-1:0]     grow_reg;

    // output register
    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    logic                  in_xfer;
    logic                  out_free;
    logic [CNT_W-1:0]      fc_dec;
    logic [GROW_W-1:0]     grow_eff;
    logic [LW-1:0]         grow_sum;
    logic [LW-1:0]         limit_eff;
    logic                  exhausted;
    logic                  fill_last;
    logic [PROD_W-1:0]     prod_full;
    logic [ADDR_WIDTH-1:0] add_a;
    logic [ADDR_WIDTH-1:0] add_b;
    logic [ADDR_WIDTH-1:0] add_sum;

    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [ADDR_WIDTH-1:0] ram_wr_data;
    logic [ADDR_WIDTH-1:0] ram_rd_data;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_xfer   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign fc_dec    = free_count_reg - CNT_W'(1);
    assign grow_eff  = (grow_count_reg == '0) ? GROW_W'(1) : grow_count_reg;
    assign grow_sum  = LW'(carved_reg) + LW'(grow_eff);
    assign limit_eff = (LW'(pool_limit_reg) < LW'(STACK_DEPTH)) ? LW'(pool_limit_reg)
                                                               : LW'(STACK_DEPTH);
    assign exhausted = grow_sum > limit_eff;
    assign prod_full = PROD_W'(carved_reg) * PROD_W'(block_bytes_reg);
    assign fill_last = LW'(idx_reg) == (LW'(grow_reg) - LW'(1));

    // shared address adder: base + offset once, then step by block size
    always_comb begin
        if (state_reg == ST_BASE) begin
            add_a = ADDR_WIDTH'(pool_base_reg);
            add_b = prod_reg;
        end else begin
            add_a = addr_reg;
            add_b = ADDR_WIDTH'(block_bytes_reg);
        end
        add_sum = add_a + add_b;
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = free_count_reg[IDX_W-1:0];
        ram_wr_data = ADDR_WIDTH'(s_tdata);
        if (state_reg == ST_FILL) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_reg;
            ram_wr_data = addr_reg;
        end else if (in_xfer && s_tuser[0] == OP_FREE && free_count_reg < carved_reg) begin
            ram_wr_en = 1'b1;
        end
    end

    fbfla_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (ADDR_WIDTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (fc_dec[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            block_bytes_reg <= RST_BLOCK_BYTES;
            grow_count_reg  <= RST_GROW_COUNT;
            pool_base_reg   <= RST_POOL_BASE;
            pool_limit_reg  <= RST_POOL_LIMIT;
            free_count_reg  <= '0;
            carved_reg      <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_BLOCK_BYTES: block_bytes_reg <= cfg_data[BLOCK_W-1:0];
                    CFG_GROW_COUNT:  grow_count_reg  <= cfg_data[GROW_W-1:0];
                    CFG_POOL_BASE:   pool_base_reg   <= cfg_data[BASE_W-1:0];
                    CFG_POOL_LIMIT:  pool_limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (s_tuser[0] == OP_FREE) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= '0;
                            if (free_count_reg < carved_reg) begin
                                free_count_reg <= free_count_reg + CNT_W'(1);
                                m_tuser_reg    <= STATUS_OK;
                            end else begin
                                m_tuser_reg <= STATUS_OVERFLOW;
                            end
                        end else if (free_count_reg != '0) begin
                            // top entry is being read this edge
                            free_count_reg <= fc_dec;
                            state_reg      <= ST_POP;
                        end else if (exhausted) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= '0;
                            m_tuser_reg  <= STATUS_EXHAUSTED;
                        end else begin
                            prod_reg  <= ADDR_WIDTH'(prod_full);
                            grow_reg  <= grow_eff;
                            state_reg <= ST_BASE;
                        end
                    end
                end
                ST_POP: begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= DATA_W'(ram_rd_data);
                    m_tuser_reg  <= STATUS_OK;
                    state_reg    <= ST_IDLE;
                end
                ST_BASE: begin
                    addr_reg  <= add_sum;
                    idx_reg   <= '0;
                    state_reg <= ST_FILL;
                end
                ST_FILL: begin
                    if (fill_last) begin
                        // highest address of the chunk goes straight out
                        carved_reg     <= CNT_W'(grow_sum);
                        free_count_reg <= CNT_W'(grow_reg) - CNT_W'(1);
                        m_tvalid_reg   <= 1'b1;
                        m_tdata_reg    <= DATA_W'(addr_reg);
                        m_tuser_reg    <= STATUS_OK;
                        state_reg      <= ST_IDLE;
                    end else begin
                        addr_reg <= add_sum;
                        idx_reg  <= idx_reg + IDX_W'(1);
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
